### hw/rtl/tdpt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdpt_pkg: shared types and constants of the trial-division prime test
// Value width, divider request/response bundles and controller states.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  // Width of the candidate value; the divider and the trial divisor follow it.
  localparam int VALUE_BITS = 31;

  // Bit counter of the serial divider: one quotient bit per cycle.
  localparam int CNT_W = $clog2(VALUE_BITS);

  // First trial divisor; candidates below it are never prime.
  localparam logic [VALUE_BITS-1:0] TRIAL_FIRST = VALUE_BITS'(2);

  typedef logic [VALUE_BITS-1:0] value_t;

  typedef struct packed {
    logic   start;
    value_t dividend;
    value_t divisor;
  } div_req_t;

  typedef struct packed {
    logic   done;
    value_t quotient;
    value_t remainder;
  } div_rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_DONE
  } tdpt_state_t;

endpackage : tdpt_pkg
`default_nettype wire

### hw/rtl/tdpt_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdpt_divider: bit-serial restoring divider
// Produces quotient and remainder one bit per cycle, and pulses done for
// one cycle with the results valid.
// ----------------------------------------------------------------------------
module tdpt_divider (
  input  wire                 clk,
  input  wire                 rst,
  input  tdpt_pkg::div_req_t  req,
  output tdpt_pkg::div_rsp_t  rsp
);
  import tdpt_pkg::*;

  logic               busy;
  logic               done;
  logic [CNT_W-1:0]   count;
  value_t             acc;
  value_t             quo;
  value_t             dsr;

  logic [VALUE_BITS:0]   shifted;
  logic [VALUE_BITS+1:0] diff;
  logic                  borrow;

  // Shift in the next dividend bit and trial-subtract the divisor.
  always_comb begin
    shifted = {acc, quo[VALUE_BITS-1]};
    diff    = {1'b0, shifted} - {2'b00, dsr};
    borrow  = diff[VALUE_BITS+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + CNT_W'(1);
        if (count == CNT_W'(VALUE_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= '0;
      quo <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      // Restore on borrow, keep the difference otherwise.
      acc <= borrow ? shifted[VALUE_BITS-1:0] : diff[VALUE_BITS-1:0];
      quo <= {quo[VALUE_BITS-2:0], ~borrow};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = acc;

endmodule : tdpt_divider
`default_nettype wire

### hw/rtl/trial_division_prime_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trial_division_prime_test: primality test by trial division
// Takes one candidate per beat and returns one is_prime beat for it.
// ----------------------------------------------------------------------------
// Each accepted candidate is tested by dividing it by 2, 3, 4, ... on one
// shared bit-serial divider. Every trial loads the divider, shifts out the
// quotient bit by bit and then judges the result. A trial stops the test with
// "not prime" when the remainder is zero and with "prime" once the divisor
// exceeds the quotient, which is the square-root bound taken without
// squaring; the bound wins when both hold. Candidates 0 and 1 go straight to
// "not prime" without a trial; at 31 bits the worst case, a prime near 2^31,
// is some 46340 trials. The block takes one candidate at a time: cand_ready
// is high only while idle, and the result is held on res_valid until the
// downstream side takes the beat.
// ----------------------------------------------------------------------------
module trial_division_prime_test (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         cand_valid,
  output logic                        cand_ready,
  input  wire  [tdpt_pkg::VALUE_BITS-1:0] candidate,
  output logic                        res_valid,
  input  wire                         res_ready,
  output logic                        is_prime
);
  import tdpt_pkg::*;

  tdpt_state_t state;
  tdpt_state_t state_next;

  value_t   n;        // candidate under test
  value_t   d;        // current trial divisor
  logic     prime;    // held result

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic     cand_beat;
  logic     below_two;
  logic     past_bound;
  logic     exact;

  assign cand_beat  = cand_valid && cand_ready;
  assign below_two  = candidate < TRIAL_FIRST;
  // Divisor above n / d means d * d > n: no factor left to find.
  assign past_bound = d > div_rsp.quotient;
  assign exact      = div_rsp.remainder == '0;

  tdpt_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cand_beat) begin
          state_next = below_two ? S_DONE : S_START;
        end
      end
      S_START: begin
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (div_rsp.done) begin
          if (past_bound || exact) begin
            state_next = S_DONE;
          end else begin
            state_next = S_START;
          end
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cand_ready       = 1'b0;
    res_valid        = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = n;
    div_req.divisor  = d;
    unique case (state)
      S_IDLE:  cand_ready    = 1'b1;
      S_START: div_req.start = 1'b1;
      S_WAIT:  ;
      S_DONE:  res_valid     = 1'b1;
      default: ;
    endcase
  end

  assign is_prime = prime;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: latch the candidate, advance the divisor, hold the verdict.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && cand_beat) begin
      n     <= candidate;
      d     <= TRIAL_FIRST;
      prime <= 1'b0;
    end else if (state == S_WAIT && div_rsp.done) begin
      if (past_bound) begin
        prime <= 1'b1;
      end else if (!exact) begin
        d <= d + VALUE_BITS'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  // Never take a new candidate while a verdict is still pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cand_ready && res_valid))
    else $error("cand_ready and res_valid high together");

  // Zero and one go straight to a "not prime" verdict.
  a_small_not_prime: assert property (@(posedge clk) disable iff (rst)
    (cand_beat && below_two) |=> (res_valid && !is_prime))
    else $error("candidate below two not answered at once as not prime");

  // The divider only finishes while the controller waits for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_WAIT))
    else $error("divider done outside the wait state");

  // A trial divisor is never below two while a division runs.
  a_divisor_floor: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) |-> (d >= TRIAL_FIRST))
    else $error("trial divisor below two");
`endif

endmodule : trial_division_prime_test
`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the trial-division prime test
// Drives candidates over a valid/ready channel, predicts the verdict of each
// accepted beat by trial division and checks every is_prime beat in order.
// ----------------------------------------------------------------------------
module tb_top;
  import tdpt_pkg::*;

  localparam int      CLK_HALF     = 10;
  localparam int      RESET_CYCLES = 7;
  localparam int      GAP_MAX      = 32;
  // Quiet cycles after the last verdict; a stray beat would show up here.
  localparam int      SETTLE_CYCLES = 64;
  // The slowest correct run is dominated by the all-ones candidate (a prime,
  // so every trial up to the square bound runs) plus the far cheaper random
  // beats; take that several times over.
  localparam longint  CYCLE_LIMIT  = 20_000_000;

  // One outstanding verdict: the candidate that was accepted and its answer.
  typedef struct {
    value_t cand;
    bit     prime;
  } verdict_t;

  logic   clk        = 1'b0;
  logic   rst        = 1'b1;
  logic   cand_valid = 1'b0;
  logic   cand_ready;
  value_t candidate  = '0;
  logic   res_valid;
  logic   res_ready  = 1'b0;
  logic   is_prime;

  verdict_t        pending_verdicts [$];
  int unsigned     failures      = 0;
  longint unsigned cycle_count   = 0;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;

  trial_division_prime_test dut (
    .clk        (clk),
    .rst        (rst),
    .cand_valid (cand_valid),
    .cand_ready (cand_ready),
    .candidate  (candidate),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .is_prime   (is_prime)
  );

  // 20 ns clock.
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Watchdog: give up if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: stall the result channel at random, at the current idle rate.
  always @(negedge clk) begin
    res_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Verdict checker: compare every is_prime beat with the oldest prediction.
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && res_valid && res_ready) begin
      if (pending_verdicts.size() == 0) begin
        failures++;
        $error("is_prime beat with no candidate outstanding: actual %0d", is_prime);
      end else begin
        want = pending_verdicts.pop_front();
        if (is_prime !== want.prime) begin
          failures++;
          $error("is_prime for candidate %0d: expected %0d, actual %0d",
                 want.cand, want.prime, is_prime);
        end
      end
    end
  end

  // Predict the verdict: values below two are not prime; otherwise try
  // divisors upward from two while d <= n / d, stopping at the first exact one.
  function automatic bit prime_by_division(input value_t n);
    longint unsigned v;
    longint unsigned d;
    v = n;
    if (v < 2) return 1'b0;
    for (d = 2; d <= v / d; d++) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Draw a candidate. Keep the cost of each test modest: large values always
  // carry a small factor, and only moderate values can turn out prime.
  function automatic value_t random_candidate();
    int unsigned     pick;
    int unsigned     f;
    int unsigned     a;
    int unsigned     b;
    int unsigned     d;
    longint unsigned n;
    pick = $urandom_range(9);
    case (pick)
      0, 1: begin
        n = $urandom_range(1023);
      end
      2, 3: begin
        n = $urandom_range(65535, 1024);
      end
      4: begin
        // Hug the square bound: d*d - 1, d*d and d*d + 1.
        d = $urandom_range(250, 2);
        n = d * d + $urandom_range(2) - 1;
      end
      5, 6, 7: begin
        // Full-width value with a small factor, so every high bit toggles.
        f = $urandom_range(97, 2);
        n = longint'(f) * $urandom_range(32'h7FFF_FFFF / f, 1);
      end
      8: begin
        a = $urandom_range(600, 2);
        b = $urandom_range(600, 2);
        n = a * b;
      end
      default: begin
        n = $urandom_range(262143, 65536) | 1;
      end
    endcase
    return value_t'(n);
  endfunction

  // Send one candidate beat. Entered at a falling edge; hold valid and the
  // payload until accepted, record the prediction, leave at a falling edge
  // with valid still high so a back-to-back beat never drops it.
  task automatic send_candidate(input value_t n);
    int       gap;
    verdict_t v;
    gap = 0;
    while (gap < GAP_MAX && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      cand_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    candidate  <= n;
    cand_valid <= 1'b1;
    do @(posedge clk); while (!cand_ready);
    v.cand  = n;
    v.prime = prime_by_division(n);
    pending_verdicts = {pending_verdicts, v};
    @(negedge clk);
  endtask

  // Hold off the sender until every outstanding verdict has come back.
  task automatic drain_verdicts();
    cand_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
  endtask

  // Change the idling pattern only once the block is quiet.
  task automatic set_idle_mode(input int send_pct, input int recv_pct);
    drain_verdicts();
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Edges of the candidate range, the two non-prime special values, perfect
  // squares of primes, and full-width values including the all-ones prime.
  task automatic test_directed_values();
    send_candidate(0);          send_candidate(1);          send_candidate(2);
    send_candidate(3);          send_candidate(4);          send_candidate(5);
    send_candidate(9);          send_candidate(25);         send_candidate(49);
    send_candidate(91);         send_candidate(97);         send_candidate(121);
    send_candidate(169);        send_candidate(8191);       send_candidate(65521);
    send_candidate(65535);      send_candidate(1000003);    send_candidate(31'h4000_0000);
    send_candidate(31'h5555_5555);
    send_candidate(31'h7FFF_FFFD);
    send_candidate(31'h7FFF_FFFE);
    // Largest candidate: prime, so every trial up to the square bound runs.
    send_candidate(31'h7FFF_FFFF);
  endtask

  // Random candidates with random content across all value classes.
  task automatic test_random_values(input int count);
    repeat (count) send_candidate(random_candidate());
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Sender idles lightly, receiver heavily.
    set_idle_mode(24, 74);
    test_directed_values();
    test_random_values(26);

    // Swap: sender idles heavily, receiver lightly.
    set_idle_mode(74, 24);
    test_random_values(26);

    // No idling on either side: back-to-back beats.
    set_idle_mode(0, 0);
    test_random_values(26);

    drain_verdicts();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule : tb_top

### files.f
hw/rtl/tdpt_pkg.sv
hw/rtl/tdpt_divider.sv
hw/rtl/trial_division_prime_test.sv
tb/sv/tb_top.sv
